// File: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque
// Command kinds, result status codes, transaction structs and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    // Command kinds
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_REMOVE     = 3'd4;
    localparam logic [2:0] KIND_LIST_FIRST = 3'd5;
    localparam logic [2:0] KIND_LIST_LAST  = 3'd6;
    localparam logic [2:0] KIND_CLEAR      = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Longest listing and the width of its count
    localparam int MAX_RESULTS = 16;
    localparam int LIST_W      = 5;

    // Input transaction
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [4:0]         list_count;
    } t_cmd;

    // Result transaction
    typedef struct packed {
        logic signed [31:0] item_value;
        logic [1:0]         status;
        logic               last_of_run;
    } t_result;

    // Per-cell control: load the new value, take the left or the right neighbor
    typedef struct packed {
        logic load;
        logic shr;
        logic shl;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell: one storage slot of the deque
// Holds one entry, takes a new value or a neighbor's entry, and compares its
// entry against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_left,
    input  wire logic signed [31:0] i_right,
    input  wire logic signed [31:0] i_key,
    output logic signed [31:0]      o_data,
    output logic                    o_match
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // Select the next entry: new value, then right shift, then left shift
    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shr) begin
            n_data = i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

`default_nettype wire

// File: src/bounded_deque_with_value_removal_unit.sv
// Timing: push, pop, clear, an empty listing and a removal on an empty store
// give their result from the execute state; any other removal scans one cell
// per cycle and answers on a match or at the last entry; a listing emits one
// value per cycle until its count is spent.
// Throughput: one command at a time; busy falls as the last result is issued.
// Reset: synchronous, active low; empties the deque, entry contents are kept.
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal_unit: bounded double-ended queue
// A row of cells holds entries front to back and shifts them between
// neighbors; a small sequencer runs pushes, pops, value removal and listings.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_value_removal_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_result_valid,
    output t_result   o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int SW = (CW > LIST_W) ? CW : LIST_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [CW-1:0]      r_occ, n_occ;
    logic [IW-1:0]      r_idx, n_idx;
    logic [LIST_W-1:0]  r_left, n_left;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_cell_ctl          w_ctl   [DEPTH];
    logic signed [31:0] w_data  [DEPTH];
    logic [DEPTH-1:0]   w_match;

    logic               w_accept;
    logic [CW-1:0]      w_last_idx;
    logic [IW-1:0]      w_rd_idx;
    logic signed [31:0] w_rd_data;
    logic [SW-1:0]      w_n;
    logic [CW-1:0]      w_start;

    assign w_accept   = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign w_last_idx = r_occ - CW'(1);

    // Row of cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            bdq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_value (r_cmd.value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_key   (r_cmd.value),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    // Read port: front or back for pops, walking index for listings
    always_comb begin
        if (r_state == S_EXEC) begin
            w_rd_idx = (r_cmd.kind == KIND_POP_FRONT) ? '0 : w_last_idx[IW-1:0];
        end else begin
            w_rd_idx = r_idx;
        end
    end
    assign w_rd_data = w_data[w_rd_idx];

    // Listing length and first position
    always_comb begin
        w_n = (SW'(r_cmd.list_count) < SW'(r_occ)) ? SW'(r_cmd.list_count) : SW'(r_occ);
        if (w_n > SW'(MAX_RESULTS)) begin
            w_n = SW'(MAX_RESULTS);
        end
        w_start = r_occ - CW'(w_n);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i] = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state           = S_IDLE;
                n_out_valid       = 1'b1;
                n_out.item_value  = '0;
                n_out.status      = ST_OK;
                n_out.last_of_run = 1'b1;
                case (r_cmd.kind) inside
                    KIND_PUSH_BACK: begin
                        if (r_occ == CW'(DEPTH)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            for (int i = 0; i < DEPTH; i++) begin
                                w_ctl[i].load = (r_occ == CW'(i));
                            end
                            n_occ = r_occ + CW'(1);
                        end
                    end
                    KIND_PUSH_FRONT: begin
                        if (r_occ == CW'(DEPTH)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl[0].load = 1'b1;
                            for (int i = 1; i < DEPTH; i++) begin
                                w_ctl[i].shr = 1'b1;
                            end
                            n_occ = r_occ + CW'(1);
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK: begin
                        if (r_occ == '0) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_out.item_value = w_rd_data;
                            n_occ            = w_last_idx;
                            if (r_cmd.kind == KIND_POP_FRONT) begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_ctl[i].shl = 1'b1;
                                end
                            end
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_occ == '0) begin
                            n_out.status = ST_NOTFOUND;
                        end else begin
                            n_out_valid = 1'b0;
                            n_idx       = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    KIND_LIST_FIRST, KIND_LIST_LAST: begin
                        if (w_n == '0) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_out_valid = 1'b0;
                            n_left      = w_n[LIST_W-1:0];
                            n_idx       = (r_cmd.kind == KIND_LIST_FIRST) ? '0
                                                                          : w_start[IW-1:0];
                            n_state     = S_LIST;
                        end
                    end
                    default: begin
                        n_occ = '0;
                    end
                endcase
            end
            S_SCAN: begin
                n_out.item_value  = '0;
                n_out.last_of_run = 1'b1;
                n_out.status      = ST_OK;
                if (w_match[r_idx]) begin
                    // Close the gap: every cell from the match onward takes its right neighbor
                    for (int i = 0; i < DEPTH; i++) begin
                        w_ctl[i].shl = (CW'(i) >= CW'(r_idx));
                    end
                    n_occ       = w_last_idx;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_idx == w_last_idx[IW-1:0]) begin
                    n_out.status = ST_NOTFOUND;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_LIST: begin
                n_out.item_value  = w_rd_data;
                n_out.status      = ST_OK;
                n_out.last_of_run = (r_left == LIST_W'(1));
                n_out_valid       = 1'b1;
                n_left            = r_left - LIST_W'(1);
                n_idx             = r_idx + IW'(1);
                if (r_left == LIST_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        r_idx  <= n_idx;
        r_left <= n_left;
        r_out  <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Occupancy never exceeds the store
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    // A result only follows work in progress
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) != S_IDLE)
        else $error("result without a command");

    // The final result of a command releases the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_of_run |-> r_state == S_IDLE)
        else $error("last result while still busy");

    // Non-ok results carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status != ST_OK) |-> o_result.item_value == '0)
        else $error("nonzero value on a failing result");

endmodule

`default_nettype wire
